// ===== rtl/core/pnas_pkg.sv =====
// ----------------------------------------------------------------------------
// pnas_pkg
// Shared widths, the arctangent table and the controller command bundle
// for the pursuit neighbour angle selector.
// ----------------------------------------------------------------------------
package pnas_pkg;

	localparam int CFG_W        = 16;
	localparam int POS_W        = 16;
	localparam int DIFF_W       = POS_W + 1;
	localparam int PRESCALE_SH  = 14;
	localparam int XY_W         = 35;
	localparam int Z_W          = 32;
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
	localparam int IDX_BITS     = 1;

	localparam logic [IDX_BITS-1:0] REG_CENTER_X = 1'b0;
	localparam logic [IDX_BITS-1:0] REG_CENTER_Y = 1'b1;

	localparam logic signed [CFG_W-1:0] CENTER_X_RST = 16'sd350;
	localparam logic signed [CFG_W-1:0] CENTER_Y_RST = 16'sd250;

	localparam logic [Z_W-1:0] HALF_CIRCLE = 32'h8000_0000;

	localparam logic [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic                 capture;
		logic                 init;
		logic                 step;
		logic [STEP_BITS-1:0] step_idx;
		logic                 round;
		logic                 commit;
	} pnas_cmd_t;

endpackage

// ===== rtl/core/pnas_ctrl.sv =====
// ----------------------------------------------------------------------------
// pnas_ctrl
// Sequencer: accepts an item, runs the rotation steps, rounds the angle and
// commits the result into the output register once it is free.
// ----------------------------------------------------------------------------
module pnas_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output pnas_pkg::pnas_cmd_t cmd
);
	import pnas_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_INIT  = 5'b00010,
		ST_ROT   = 5'b00100,
		ST_ROUND = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(CORDIC_STEPS - 1);

	state_t               state_q, state_d;
	logic [STEP_BITS-1:0] cnt_q;
	logic                 out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.step_idx = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_ROT;
			end
			ST_ROT: begin
				cmd.step = 1'b1;
				if (cnt_q == LAST_STEP) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.init) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/pnas_dp.sv =====
// ----------------------------------------------------------------------------
// pnas_dp
// Datapath: centre registers, offset and prescale, shared vectoring rotator,
// angle rounding and the own/neighbour tracking state.
// ----------------------------------------------------------------------------
module pnas_dp #(
	parameter int ANGLE_BITS = 16,
	parameter int ID_BITS    = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pnas_pkg::pnas_cmd_t                 cmd,
	input  logic                                wr_en,
	input  logic [pnas_pkg::IDX_BITS-1:0]       wr_index,
	input  logic [pnas_pkg::CFG_W-1:0]          wr_data,
	input  logic                                req_type,
	input  logic [ID_BITS-1:0]                  robot_id,
	input  logic signed [pnas_pkg::POS_W-1:0]   pos_x,
	input  logic signed [pnas_pkg::POS_W-1:0]   pos_y,
	output logic [ANGLE_BITS-1:0]               gap_angle,
	output logic [ID_BITS-1:0]                  neighbor_id,
	output logic                                neighbor_valid
);
	import pnas_pkg::*;

	localparam int RND_SH = Z_W - ANGLE_BITS;
	localparam longint unsigned FULL_CIRCLE = 64'd1 << ANGLE_BITS;
	localparam longint unsigned ONE_RAD  = (FULL_CIRCLE * 64'd2000000 + 64'd6283185) / 64'd12566370;
	localparam longint unsigned FOUR_RAD = (FULL_CIRCLE * 64'd8000000 + 64'd6283185) / 64'd12566370;
	localparam logic [ANGLE_BITS-1:0] ONE_RAD_RST  = ANGLE_BITS'(ONE_RAD);
	localparam logic [ANGLE_BITS-1:0] FOUR_RAD_RST = ANGLE_BITS'(FOUR_RAD);

	logic signed [CFG_W-1:0]  center_x_q, center_y_q;
	logic                     type_q;
	logic [ID_BITS-1:0]       id_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic signed [XY_W-1:0]   x_q, y_q;
	logic [Z_W-1:0]           z_q;
	logic                     zero_q;
	logic [ANGLE_BITS-1:0]    ang_q;

	logic [ID_BITS-1:0]       self_id_q;
	logic                     self_known_q;
	logic [ANGLE_BITS-1:0]    self_angle_q;
	logic [ID_BITS-1:0]       trk_id_q;
	logic                     trk_valid_q;
	logic [ANGLE_BITS-1:0]    trk_gap_q;

	logic signed [XY_W-1:0]   dx_ext, dy_ext, x_init, y_init, x_sh, y_sh;
	logic                     neg, y_pos;
	logic [ANGLE_BITS-1:0]    ang_rnd, gap;
	logic                     is_self, take_any, take_less;

	always_comb begin
		neg    = dx_q[DIFF_W-1];
		dx_ext = XY_W'(dx_q) <<< PRESCALE_SH;
		dy_ext = XY_W'(dy_q) <<< PRESCALE_SH;
		x_init = neg ? -dx_ext : dx_ext;
		y_init = neg ? -dy_ext : dy_ext;
		x_sh   = x_q >>> cmd.step_idx;
		y_sh   = y_q >>> cmd.step_idx;
		y_pos  = !y_q[XY_W-1] && (y_q != '0);
	end

	generate
		if (RND_SH > 0) begin : g_round
			logic [Z_W-1:0] z_rnd;
			assign z_rnd   = z_q + (Z_W'(1) << (RND_SH - 1));
			assign ang_rnd = ANGLE_BITS'(z_rnd >> RND_SH);
		end else begin : g_exact
			assign ang_rnd = ANGLE_BITS'(z_q);
		end
	endgenerate

	always_comb begin
		gap       = ang_q - self_angle_q;
		is_self   = self_known_q && (id_q == self_id_q);
		take_any  = !trk_valid_q || (trk_id_q == id_q);
		take_less = gap < trk_gap_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q <= req_type;
			id_q   <= robot_id;
			dx_q   <= DIFF_W'(pos_x) - DIFF_W'(center_x_q);
			dy_q   <= DIFF_W'(pos_y) - DIFF_W'(center_y_q);
		end
		if (cmd.init) begin
			x_q    <= x_init;
			y_q    <= y_init;
			z_q    <= neg ? HALF_CIRCLE : '0;
			zero_q <= (dx_q == '0) && (dy_q == '0);
		end else if (cmd.step) begin
			if (y_pos) begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + ATAN_TAB[cmd.step_idx];
			end else begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - ATAN_TAB[cmd.step_idx];
			end
		end
		if (cmd.round) begin
			ang_q <= zero_q ? '0 : ang_rnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q   <= CENTER_X_RST;
			center_y_q   <= CENTER_Y_RST;
			self_id_q    <= '0;
			self_known_q <= 1'b0;
			self_angle_q <= ONE_RAD_RST;
			trk_id_q     <= '0;
			trk_valid_q  <= 1'b0;
			trk_gap_q    <= FOUR_RAD_RST;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_CENTER_X: center_x_q <= wr_data;
					REG_CENTER_Y: center_y_q <= wr_data;
					default: ;
				endcase
			end
			if (cmd.commit) begin
				if (!type_q) begin
					self_id_q    <= id_q;
					self_known_q <= 1'b1;
					self_angle_q <= ang_q;
				end else if (!is_self) begin
					if (take_any) begin
						trk_valid_q <= 1'b1;
						trk_id_q    <= id_q;
						trk_gap_q   <= gap;
					end else if (take_less) begin
						trk_id_q  <= id_q;
						trk_gap_q <= gap;
					end
				end
			end
		end
	end

	assign gap_angle      = trk_gap_q;
	assign neighbor_id    = trk_id_q;
	assign neighbor_valid = trk_valid_q;

endmodule

// ===== rtl/core/pursuit_neighbor_angle_select.sv =====
// ----------------------------------------------------------------------------
// pursuit_neighbor_angle_select
// Turns pose reports into full-circle angles about a configurable centre and
// tracks the nearest neighbour ahead of the own robot.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result: the tracked gap, neighbour id
// and valid flag after the report is applied. An item occupies the block from
// acceptance through capture, prescale, the 24-step vectoring rotator (one
// step per cycle), rounding and commit; only then is the next item accepted.
// The result sits in an output register, so a new item is accepted while an
// earlier result still waits to be taken. Angles use 2^ANGLE_BITS for the
// full circle; a position at the centre gives angle zero. Centre registers
// must be written only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module pursuit_neighbor_angle_select #(
	parameter int ANGLE_BITS = 16,
	parameter int ID_BITS    = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [pnas_pkg::IDX_BITS-1:0]     wr_index,
	input  logic [pnas_pkg::CFG_W-1:0]        wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic [ID_BITS-1:0]                robot_id,
	input  logic signed [pnas_pkg::POS_W-1:0] pos_x,
	input  logic signed [pnas_pkg::POS_W-1:0] pos_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ANGLE_BITS-1:0]             gap_angle,
	output logic [ID_BITS-1:0]                neighbor_id,
	output logic                              neighbor_valid
);
	import pnas_pkg::*;

	pnas_cmd_t cmd;

	pnas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	pnas_dp #(
		.ANGLE_BITS (ANGLE_BITS),
		.ID_BITS    (ID_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.req_type       (req_type),
		.robot_id       (robot_id),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.gap_angle      (gap_angle),
		.neighbor_id    (neighbor_id),
		.neighbor_valid (neighbor_valid)
	);

endmodule

// ===== tb/tb_pursuit_neighbor_angle_select.sv =====
// ----------------------------------------------------------------------------
// tb_pursuit_neighbor_angle_select
// Self-checking bench for the pursuit neighbour angle selector. Pose reports
// go in over a valid/stall channel. A bit-accurate tracker built into the
// bench (a vectoring arctangent plus the own/peer bookkeeping) predicts every
// result, and each result is checked field by field in arrival order. The
// run starts with directed corner cases and centre extremes. Random traffic
// follows under several centre settings and sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_pursuit_neighbor_angle_select;
	import pnas_pkg::*;

	localparam int ANGLE_W      = 16;
	localparam int ID_W         = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_GAP      = 40;

	localparam logic OWN_REPORT  = 1'b0;
	localparam logic PEER_REPORT = 1'b1;

	localparam logic [ANGLE_W-1:0] ONE_RADIAN   = 16'd10430;
	localparam logic [ANGLE_W-1:0] FOUR_RADIANS = 16'd41722;

	typedef struct packed {
		logic [ANGLE_W-1:0] gap;
		logic [ID_W-1:0]    id;
		logic               valid;
	} nbr_result_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    wr_en     = 1'b0;
	logic [IDX_BITS-1:0]     wr_index  = '0;
	logic [CFG_W-1:0]        wr_data   = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	logic                    req_type  = OWN_REPORT;
	logic [ID_W-1:0]         robot_id  = '0;
	logic signed [POS_W-1:0] pos_x     = '0;
	logic signed [POS_W-1:0] pos_y     = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [ANGLE_W-1:0]      gap_angle;
	logic [ID_W-1:0]         neighbor_id;
	logic                    neighbor_valid;

	logic signed [CFG_W-1:0] trk_centre_x;
	logic signed [CFG_W-1:0] trk_centre_y;
	logic [ID_W-1:0]         trk_self_id;
	logic                    trk_self_known;
	logic [ANGLE_W-1:0]      trk_self_angle;
	logic [ID_W-1:0]         trk_nbr_id;
	logic                    trk_nbr_valid;
	logic [ANGLE_W-1:0]      trk_nbr_gap;

	nbr_result_t pending_results[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycles         = 0;
	int mismatches     = 0;
	int reports_sent   = 0;
	int own_reports    = 0;
	int results_seen   = 0;
	int centre_writes  = 0;

	logic signed [POS_W-1:0] last_x = '0;
	logic signed [POS_W-1:0] last_y = '0;

	pursuit_neighbor_angle_select #(
		.ANGLE_BITS(ANGLE_W),
		.ID_BITS   (ID_W)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.robot_id      (robot_id),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.gap_angle     (gap_angle),
		.neighbor_id   (neighbor_id),
		.neighbor_valid(neighbor_valid)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [ANGLE_W-1:0] bearing(int dx, int dy);
		longint x, y, nx, ny;
		logic [Z_W-1:0] z;
		if (dx == 0 && dy == 0) return '0;
		x = longint'(dx) <<< PRESCALE_SH;
		y = longint'(dy) <<< PRESCALE_SH;
		z = '0;
		if (dx < 0) begin
			x = -x;
			y = -y;
			z = HALF_CIRCLE;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z  = z + ATAN_TAB[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z  = z - ATAN_TAB[i];
			end
			x = nx;
			y = ny;
		end
		z = z + (32'd1 << (Z_W - ANGLE_W - 1));
		return z[Z_W-1 -: ANGLE_W];
	endfunction

	function automatic void track_report(logic kind, logic [ID_W-1:0] id,
			logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py);
		logic [ANGLE_W-1:0] ang, gap;
		nbr_result_t res;
		ang = bearing(int'(px) - int'(trk_centre_x), int'(py) - int'(trk_centre_y));
		if (kind == OWN_REPORT) begin
			trk_self_id    = id;
			trk_self_known = 1'b1;
			trk_self_angle = ang;
		end else if (!(trk_self_known && id == trk_self_id)) begin
			gap = ang - trk_self_angle;
			if (!trk_nbr_valid || trk_nbr_id == id) begin
				trk_nbr_valid = 1'b1;
				trk_nbr_id    = id;
				trk_nbr_gap   = gap;
			end else if (gap < trk_nbr_gap) begin
				trk_nbr_id  = id;
				trk_nbr_gap = gap;
			end
		end
		res.gap   = trk_nbr_gap;
		res.id    = trk_nbr_id;
		res.valid = trk_nbr_valid;
		pending_results.push_back(res);
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pos(int v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return v[POS_W-1:0];
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t  mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_report(logic kind, logic [ID_W-1:0] id,
			logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py);
		int gap_cycles;
		gap_cycles = 0;
		while (gap_cycles < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap_cycles++;
		if (gap_cycles > 0) begin
			in_valid <= 1'b0;
			repeat (gap_cycles) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		robot_id <= id;
		pos_x    <= px;
		pos_y    <= py;
		do @(posedge clk); while (in_stall);
		track_report(kind, id, px, py);
		reports_sent++;
		if (kind == OWN_REPORT)
			own_reports++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_centre(logic [IDX_BITS-1:0] idx, logic signed [CFG_W-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_CENTER_X)
			trk_centre_x = val;
		else
			trk_centre_y = val;
		centre_writes++;
	endtask

	task automatic set_centre(logic signed [CFG_W-1:0] cx, logic signed [CFG_W-1:0] cy);
		wait_idle();
		write_centre(REG_CENTER_X, cx);
		write_centre(REG_CENTER_Y, cy);
	endtask

	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_report(PEER_REPORT, 8'd7, 16'sd350, 16'sd250);
		send_report(OWN_REPORT, 8'd0, 16'sd32767, 16'sd250);
		send_report(PEER_REPORT, 8'd0, 16'sd0, 16'sd0);
		send_report(PEER_REPORT, 8'd7, -16'sd32768, 16'sd250);
		send_report(PEER_REPORT, 8'd8, -16'sd32768, 16'sd250);
		send_report(PEER_REPORT, 8'd9, 16'sd350, 16'sd32767);
		send_report(PEER_REPORT, 8'd10, 16'sd350, -16'sd32768);
		send_report(PEER_REPORT, 8'd9, 16'sd32767, 16'sd32767);
		send_report(PEER_REPORT, 8'd255, -16'sd32768, 16'sd32767);
		send_report(OWN_REPORT, 8'd255, 16'sd350, 16'sd250);
		send_report(PEER_REPORT, 8'd255, 16'sd32767, -16'sd32768);
		send_report(PEER_REPORT, 8'd0, -16'sd32768, -16'sd32768);
		send_report(PEER_REPORT, 8'd128, 16'sd32767, 16'sd32767);
		send_report(OWN_REPORT, 8'd128, 16'sd350, -16'sd32768);
		send_report(PEER_REPORT, 8'd1, 16'sd349, 16'sd249);
		send_report(PEER_REPORT, 8'd3, 16'sd351, 16'sd250);
		send_report(PEER_REPORT, 8'd4, 16'sd350, 16'sd251);
		send_report(PEER_REPORT, 8'd5, 16'sd349, 16'sd250);
		send_report(OWN_REPORT, 8'd7, -16'sd32768, -16'sd32768);
		send_report(PEER_REPORT, 8'd7, 16'sd100, 16'sd100);
		send_report(PEER_REPORT, 8'd170, 16'sd350, 16'sd249);
	endtask

	task automatic test_centre_extremes();
		set_centre(-16'sd32768, -16'sd32768);
		send_report(OWN_REPORT, 8'd1, 16'sd32767, 16'sd32767);
		send_report(PEER_REPORT, 8'd2, 16'sd32767, -16'sd32768);
		send_report(PEER_REPORT, 8'd3, -16'sd32768, 16'sd32767);
		send_report(PEER_REPORT, 8'd4, -16'sd32768, -16'sd32768);
		set_centre(16'sd32767, 16'sd32767);
		send_report(PEER_REPORT, 8'd5, -16'sd32768, -16'sd32768);
		send_report(PEER_REPORT, 8'd6, 16'sd32767, -16'sd32768);
		send_report(OWN_REPORT, 8'd6, -16'sd32768, 16'sd32767);
		send_report(PEER_REPORT, 8'd2, 16'sd32767, 16'sd32767);
		set_centre(-16'sd32768, 16'sd32767);
		send_report(PEER_REPORT, 8'd5, 16'sd32767, -16'sd32768);
		send_report(PEER_REPORT, 8'd9, 16'sd0, 16'sd0);
	endtask

	task automatic send_random_report();
		logic kind;
		logic [ID_W-1:0] id;
		logic signed [POS_W-1:0] rx, ry;
		int px, py, sel;
		kind = ($urandom_range(99) < 15) ? OWN_REPORT : PEER_REPORT;
		id   = ($urandom_range(99) < 70) ? ID_W'($urandom_range(5)) : ID_W'($urandom);
		rx   = POS_W'($urandom);
		ry   = POS_W'($urandom);
		px   = rx;
		py   = ry;
		sel  = $urandom_range(99);
		if (sel >= 95) begin
			px = trk_centre_x;
			py = trk_centre_y;
		end else if (sel >= 85) begin
			if ($urandom_range(1))
				px = trk_centre_x;
			else
				py = trk_centre_y;
		end else if (sel >= 72) begin
			px = last_x;
			py = last_y;
		end else if (sel >= 55) begin
			px = int'(trk_centre_x) + int'($urandom_range(16)) - 8;
			py = int'(trk_centre_y) + int'($urandom_range(16)) - 8;
		end
		last_x = clamp_pos(px);
		last_y = clamp_pos(py);
		send_report(kind, id, last_x, last_y);
	endtask

	task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_random_report();
	endtask

	task automatic test_pause_for_drain();
		send_idle_pct  = 72;
		recv_stall_pct = 72;
		repeat (10) send_random_report();
		wait_idle();
		repeat (10) send_random_report();
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin : check_results
		nbr_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending, gap", gap_angle, -1);
			end else begin
				want = pending_results.pop_front();
				if (gap_angle !== want.gap)
					report_mismatch("gap_angle", gap_angle, want.gap);
				if (neighbor_id !== want.id)
					report_mismatch("neighbor_id", neighbor_id, want.id);
				if (neighbor_valid !== want.valid)
					report_mismatch("neighbor_valid", neighbor_valid, want.valid);
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles, %0d results outstanding",
				cycles, pending_results.size());
			$display("tb_pursuit_neighbor_angle_select: done, errors");
			$finish;
		end
	end

	initial begin
		trk_centre_x   = CENTER_X_RST;
		trk_centre_y   = CENTER_Y_RST;
		trk_self_id    = '0;
		trk_self_known = 1'b0;
		trk_self_angle = ONE_RADIAN;
		trk_nbr_id     = '0;
		trk_nbr_valid  = 1'b0;
		trk_nbr_gap    = FOUR_RADIANS;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_centre_extremes();
		set_centre(16'sd0, 16'sd0);
		test_random_traffic(100, 0, 0);
		set_centre(POS_W'($urandom), POS_W'($urandom));
		test_random_traffic(100, 72, 0);
		set_centre(16'sd350, 16'sd250);
		test_random_traffic(100, 0, 72);
		set_centre(CFG_W'($urandom_range(2000)) - 16'sd1000,
			CFG_W'($urandom_range(2000)) - 16'sd1000);
		test_random_traffic(100, 8, 8);
		test_pause_for_drain();
		wait_idle();

		$display("coverage: %0d reports (%0d own), %0d results checked, %0d centre writes",
			reports_sent, own_reports, results_seen, centre_writes);
		$display("idling mixes: none, sender only, receiver only, both light, both heavy");
		if (mismatches == 0)
			$display("tb_pursuit_neighbor_angle_select: done, clean");
		else
			$display("tb_pursuit_neighbor_angle_select: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/pnas_pkg.sv
rtl/core/pnas_ctrl.sv
rtl/core/pnas_dp.sv
rtl/core/pursuit_neighbor_angle_select.sv
tb/tb_pursuit_neighbor_angle_select.sv
